// ===== design/i2cm_pkg.sv =====
// Shared types and constants for the I2C master transaction engine.
// No dependencies; imported by i2cm_front, i2cm_engine and the top level.
package i2cm_pkg;

  // Command codes on the input channel
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_BEGIN  = 2'd1;
  localparam logic [1:0] CMD_SUPPLY = 2'd2;

  // Bit positions inside the line drive register
  localparam int DRV_SCL = 0;
  localparam int DRV_SDA = 1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_BEGIN,
    KIND_SUPPLY,
    KIND_NONE
  } cmd_kind_t;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_ST_WAIT  = 5'd1,
    PH_ST_D1    = 5'd2,
    PH_ST_D2    = 5'd3,
    PH_TX_D1    = 5'd4,
    PH_TX_WAIT  = 5'd5,
    PH_TX_D2    = 5'd6,
    PH_ACK_D1   = 5'd7,
    PH_ACK_WAIT = 5'd8,
    PH_ACK_D2   = 5'd9,
    PH_NEED     = 5'd10,
    PH_RX_D1    = 5'd11,
    PH_RX_WAIT  = 5'd12,
    PH_RX_D2    = 5'd13,
    PH_MA_D1    = 5'd14,
    PH_MA_WAIT  = 5'd15,
    PH_MA_D2    = 5'd16,
    PH_SP_D1    = 5'd17,
    PH_SP_WAIT  = 5'd18,
    PH_SP_D2    = 5'd19,
    PH_SP_D3    = 5'd20
  } phase_t;

  // One classified transaction as it waits in the queue (length kept apart)
  typedef struct packed {
    cmd_kind_t   kind;
    logic        is_read;
    logic [6:0]  addr7;
    logic [7:0]  data_byte;
    logic        scl_in;
    logic        sda_in;
  } cmd_entry_t;

endpackage

// ===== design/i2cm_front.sv =====
// Front end: classifies incoming transactions and holds them in a two-entry queue.
// Depends on i2cm_pkg.
module i2cm_front #(
  parameter int LEN_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_cmd,
  input  logic                  in_is_read,
  input  logic [6:0]            in_addr7,
  input  logic [LEN_BITS-1:0]   in_length,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_scl_in,
  input  logic                  in_sda_in,
  output logic                  q_avail,
  output i2cm_pkg::cmd_entry_t  q_entry,
  output logic [LEN_BITS-1:0]   q_length,
  input  logic                  q_pop
);
  import i2cm_pkg::*;

  cmd_entry_t          mem_entry [QUEUE_DEPTH];
  logic [LEN_BITS-1:0] mem_length [QUEUE_DEPTH];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          count_r, count_nxt;
  logic                push;
  cmd_entry_t          new_entry;

  assign in_stall = (count_r == 2'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_avail  = (count_r != 2'd0);
  assign q_entry  = mem_entry[rd_ptr_r];
  assign q_length = mem_length[rd_ptr_r];

  always_comb begin
    new_entry           = '0;
    new_entry.is_read   = in_is_read;
    new_entry.addr7     = in_addr7;
    new_entry.data_byte = in_data_byte;
    new_entry.scl_in    = in_scl_in;
    new_entry.sda_in    = in_sda_in;
    case (in_cmd)
      CMD_TICK:   new_entry.kind = KIND_TICK;
      CMD_BEGIN:  new_entry.kind = KIND_BEGIN;
      CMD_SUPPLY: new_entry.kind = KIND_SUPPLY;
      default:    new_entry.kind = KIND_NONE;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_entry[wr_ptr_r]  <= new_entry;
      mem_length[wr_ptr_r] <= in_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/i2cm_engine.sv =====
// Back end: bus phase state machine, delay counter and registered result stage.
// Depends on i2cm_pkg; fed from i2cm_front.
module i2cm_engine #(
  parameter int LEN_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           phase_ticks,
  input  logic                  q_avail,
  input  i2cm_pkg::cmd_entry_t  q_entry,
  input  logic [LEN_BITS-1:0]   q_length,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_scl_pull_low,
  output logic                  out_sda_pull_low,
  output logic                  out_need_byte,
  output logic                  out_read_valid,
  output logic [7:0]            out_read_data,
  output logic                  out_done_res,
  output logic                  out_success,
  output logic                  out_busy_res
);
  import i2cm_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [15:0]         delay_count_r, delay_count_nxt;
  logic [3:0]          bit_index_r, bit_index_nxt;
  logic [7:0]          shift_byte_r, shift_byte_nxt;
  logic [LEN_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [6:0]          target_addr_r, target_addr_nxt;
  logic                read_mode_r, read_mode_nxt;
  logic [1:0]          line_drive_r, line_drive_nxt;
  logic                failed_r, failed_nxt;

  logic                out_valid_r;
  logic                scl_r, sda_r, need_r, rvalid_r, done_r, success_r, busy_r;
  logic [7:0]          rdata_r;

  logic                slot_free;
  logic                ev_valid, ev_done;
  logic [16:0]         cnt_inc;
  logic [15:0]         limit;
  logic                elapsed;
  logic [3:0]          bit_inc;
  logic [LEN_BITS-1:0] left_dec;
  logic [7:0]          rx_shift;

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = q_avail && slot_free;

  assign cnt_inc  = {1'b0, delay_count_r} + 17'd1;
  assign limit    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign elapsed  = cnt_inc >= {1'b0, limit};
  assign bit_inc  = bit_index_r + 4'd1;
  assign left_dec = bytes_left_r - LEN_BITS'(1);
  assign rx_shift = {shift_byte_r[6:0], q_entry.sda_in};

  always_comb begin
    phase_nxt       = phase_r;
    delay_count_nxt = delay_count_r;
    bit_index_nxt   = bit_index_r;
    shift_byte_nxt  = shift_byte_r;
    bytes_left_nxt  = bytes_left_r;
    target_addr_nxt = target_addr_r;
    read_mode_nxt   = read_mode_r;
    line_drive_nxt  = line_drive_r;
    failed_nxt      = failed_r;
    ev_valid        = 1'b0;
    ev_done         = 1'b0;

    if (q_pop) begin
      case (q_entry.kind)
        KIND_BEGIN: begin
          if (phase_r == PH_IDLE) begin
            read_mode_nxt   = q_entry.is_read;
            target_addr_nxt = q_entry.addr7;
            bytes_left_nxt  = q_length;
            failed_nxt      = 1'b0;
            line_drive_nxt  = 2'b00;
            bit_index_nxt   = 4'd0;
            shift_byte_nxt  = 8'd0;
            phase_nxt       = PH_ST_WAIT;
            delay_count_nxt = 16'd0;
          end
        end
        KIND_SUPPLY: begin
          if (phase_r == PH_NEED) begin
            shift_byte_nxt          = q_entry.data_byte;
            bytes_left_nxt          = left_dec;
            bit_index_nxt           = 4'd0;
            line_drive_nxt[DRV_SDA] = !q_entry.data_byte[7];
            phase_nxt               = PH_TX_D1;
            delay_count_nxt         = 16'd0;
          end
        end
        KIND_TICK: begin
          case (phase_r)
            PH_ST_WAIT, PH_TX_WAIT, PH_ACK_WAIT, PH_RX_WAIT, PH_MA_WAIT,
            PH_SP_WAIT: begin
              if (q_entry.scl_in) begin
                delay_count_nxt = 16'd0;
                case (phase_r)
                  PH_ST_WAIT:  phase_nxt = PH_ST_D1;
                  PH_TX_WAIT:  phase_nxt = PH_TX_D2;
                  PH_ACK_WAIT: phase_nxt = PH_ACK_D2;
                  PH_RX_WAIT:  phase_nxt = PH_RX_D2;
                  PH_MA_WAIT:  phase_nxt = PH_MA_D2;
                  default:     phase_nxt = PH_SP_D2;
                endcase
              end
            end
            PH_ST_D1, PH_ST_D2, PH_TX_D1, PH_TX_D2, PH_ACK_D1, PH_ACK_D2,
            PH_RX_D1, PH_RX_D2, PH_MA_D1, PH_MA_D2, PH_SP_D1, PH_SP_D2,
            PH_SP_D3: begin
              // every expiring delay moves to a new phase, so the count restarts
              delay_count_nxt = elapsed ? 16'd0 : cnt_inc[15:0];
              if (elapsed) begin
                case (phase_r)
                  PH_ST_D1: begin
                    line_drive_nxt[DRV_SDA] = 1'b1;
                    phase_nxt               = PH_ST_D2;
                  end
                  PH_ST_D2: begin
                    line_drive_nxt[DRV_SCL] = 1'b1;
                    shift_byte_nxt          = {target_addr_r, read_mode_r};
                    bit_index_nxt           = 4'd0;
                    line_drive_nxt[DRV_SDA] = !target_addr_r[6];
                    phase_nxt               = PH_TX_D1;
                  end
                  PH_TX_D1, PH_ACK_D1, PH_RX_D1, PH_MA_D1, PH_SP_D1: begin
                    line_drive_nxt[DRV_SCL] = 1'b0;
                    case (phase_r)
                      PH_TX_D1:  phase_nxt = PH_TX_WAIT;
                      PH_ACK_D1: phase_nxt = PH_ACK_WAIT;
                      PH_RX_D1:  phase_nxt = PH_RX_WAIT;
                      PH_MA_D1:  phase_nxt = PH_MA_WAIT;
                      default:   phase_nxt = PH_SP_WAIT;
                    endcase
                  end
                  PH_TX_D2: begin
                    line_drive_nxt[DRV_SCL] = 1'b1;
                    bit_index_nxt           = bit_inc;
                    if (bit_inc < 4'd8) begin
                      line_drive_nxt[DRV_SDA] = !shift_byte_r[3'd7 - bit_inc[2:0]];
                      phase_nxt               = PH_TX_D1;
                    end else begin
                      line_drive_nxt[DRV_SDA] = 1'b0;
                      phase_nxt               = PH_ACK_D1;
                    end
                  end
                  PH_ACK_D2: begin
                    line_drive_nxt[DRV_SCL] = 1'b1;
                    if (q_entry.sda_in) begin
                      // NAK from the device: abandon with a stop
                      failed_nxt              = 1'b1;
                      line_drive_nxt[DRV_SDA] = 1'b1;
                      phase_nxt               = PH_SP_D1;
                    end else if (bytes_left_r == '0) begin
                      line_drive_nxt[DRV_SDA] = 1'b1;
                      phase_nxt               = PH_SP_D1;
                    end else if (read_mode_r) begin
                      line_drive_nxt[DRV_SDA] = 1'b0;
                      bit_index_nxt           = 4'd0;
                      shift_byte_nxt          = 8'd0;
                      phase_nxt               = PH_RX_D1;
                    end else begin
                      phase_nxt = PH_NEED;
                    end
                  end
                  PH_RX_D2: begin
                    shift_byte_nxt          = rx_shift;
                    line_drive_nxt[DRV_SCL] = 1'b1;
                    bit_index_nxt           = bit_inc;
                    if (bit_inc < 4'd8) begin
                      phase_nxt = PH_RX_D1;
                    end else begin
                      bytes_left_nxt          = left_dec;
                      ev_valid                = 1'b1;
                      // master ACK unless this was the last byte
                      line_drive_nxt[DRV_SDA] = (left_dec != '0);
                      phase_nxt               = PH_MA_D1;
                    end
                  end
                  PH_MA_D2: begin
                    line_drive_nxt[DRV_SCL] = 1'b1;
                    if (bytes_left_r == '0) begin
                      line_drive_nxt[DRV_SDA] = 1'b1;
                      phase_nxt               = PH_SP_D1;
                    end else begin
                      line_drive_nxt[DRV_SDA] = 1'b0;
                      bit_index_nxt           = 4'd0;
                      shift_byte_nxt          = 8'd0;
                      phase_nxt               = PH_RX_D1;
                    end
                  end
                  PH_SP_D2: begin
                    line_drive_nxt[DRV_SDA] = 1'b0;
                    phase_nxt               = PH_SP_D3;
                  end
                  default: begin
                    ev_done   = 1'b1;
                    phase_nxt = PH_IDLE;
                  end
                endcase
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      delay_count_r <= 16'd0;
      bit_index_r   <= 4'd0;
      shift_byte_r  <= 8'd0;
      bytes_left_r  <= '0;
      target_addr_r <= 7'd0;
      read_mode_r   <= 1'b0;
      line_drive_r  <= 2'b00;
      failed_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      delay_count_r <= delay_count_nxt;
      bit_index_r   <= bit_index_nxt;
      shift_byte_r  <= shift_byte_nxt;
      bytes_left_r  <= bytes_left_nxt;
      target_addr_r <= target_addr_nxt;
      read_mode_r   <= read_mode_nxt;
      line_drive_r  <= line_drive_nxt;
      failed_r      <= failed_nxt;
      if (slot_free) out_valid_r <= q_avail;
    end
  end

  // result payload, loaded whenever a transaction is taken from the queue
  always_ff @(posedge clk) begin
    if (q_pop) begin
      scl_r     <= line_drive_nxt[DRV_SCL];
      sda_r     <= line_drive_nxt[DRV_SDA];
      need_r    <= (phase_nxt == PH_NEED);
      rvalid_r  <= ev_valid;
      rdata_r   <= ev_valid ? shift_byte_nxt : 8'd0;
      done_r    <= ev_done;
      success_r <= ev_done && !failed_nxt;
      busy_r    <= (phase_nxt != PH_IDLE);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl_pull_low = scl_r;
  assign out_sda_pull_low = sda_r;
  assign out_need_byte    = need_r;
  assign out_read_valid   = rvalid_r;
  assign out_read_data    = rdata_r;
  assign out_done_res     = done_r;
  assign out_success      = success_r;
  assign out_busy_res     = busy_r;

  // a pending result always reflects the phase the engine now sits in
  a_rvalid_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rvalid_r) |-> (phase_r == PH_MA_D1))
    else $error("read byte result outside master ACK phase");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (phase_r == PH_IDLE && !busy_r))
    else $error("done result while engine not idle");

  a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && success_r) |-> done_r)
    else $error("success without done");

  a_need_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (need_r == (phase_r == PH_NEED)))
    else $error("need_byte disagrees with engine phase");

endmodule

// ===== design/i2c_master_transaction_engine_top.sv =====
// I2C master transaction engine, top level: classifier queue plus bus engine.
// Depends on i2cm_pkg, i2cm_front and i2cm_engine.
//
// Usage: every transaction on the in_ channel (tick with sampled pins, begin,
// or supply write byte) yields exactly one result on the out_ channel, in order,
// carrying the open-drain pull-low levels and the status flags after that step.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. cfg_we writes cfg_wdata into phase_ticks, the tick count of
// each delay phase; write it only while the block is idle.
// Order: the queue captures a transaction on the accepting edge; the engine's result
// register loads its result when it is popped, which waits while a result stalls.
// Throughput: one transaction per clock while out_stall is low, set by the phase state
// machine and delay counter step in the engine.
// Reset (rst_n low, synchronous): queue empty, engine idle with both lines
// released, phase_ticks back to 500.
// Receiver stall: the result register holds, the engine pauses, the queue
// fills and in_stall rises once both entries are occupied.
module i2c_master_transaction_engine_top #(
  parameter int LEN_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_cmd,
  input  logic                in_is_read,
  input  logic [6:0]          in_addr7,
  input  logic [LEN_BITS-1:0] in_length,
  input  logic [7:0]          in_data_byte,
  input  logic                in_scl_in,
  input  logic                in_sda_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_scl_pull_low,
  output logic                out_sda_pull_low,
  output logic                out_need_byte,
  output logic                out_read_valid,
  output logic [7:0]          out_read_data,
  output logic                out_done_res,
  output logic                out_success,
  output logic                out_busy_res
);
  import i2cm_pkg::*;

  logic [15:0]         phase_ticks_r;
  logic                q_avail, q_pop;
  cmd_entry_t          q_entry;
  logic [LEN_BITS-1:0] q_length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= 16'd500;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  i2cm_front #(.LEN_BITS(LEN_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_is_read   (in_is_read),
    .in_addr7     (in_addr7),
    .in_length    (in_length),
    .in_data_byte (in_data_byte),
    .in_scl_in    (in_scl_in),
    .in_sda_in    (in_sda_in),
    .q_avail      (q_avail),
    .q_entry      (q_entry),
    .q_length     (q_length),
    .q_pop        (q_pop)
  );

  i2cm_engine #(.LEN_BITS(LEN_BITS)) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .phase_ticks      (phase_ticks_r),
    .q_avail          (q_avail),
    .q_entry          (q_entry),
    .q_length         (q_length),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scl_pull_low (out_scl_pull_low),
    .out_sda_pull_low (out_sda_pull_low),
    .out_need_byte    (out_need_byte),
    .out_read_valid   (out_read_valid),
    .out_read_data    (out_read_data),
    .out_done_res     (out_done_res),
    .out_success      (out_success),
    .out_busy_res     (out_busy_res)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking bench for i2c_master_transaction_engine_top: bursty driver, stalling monitor
// and a transaction-level model of the I2C phase machine that predicts every result.
// Depends on i2cm_pkg and the engine RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [15:0] RESET_TICKS = 16'd500;
  localparam longint unsigned LIMIT   = 600_000;

  typedef struct {
    logic [1:0] cmd;
    logic       is_read;
    logic [6:0] addr7;
    logic [7:0] nbytes;
    logic [7:0] data_byte;
    logic       scl_in;
    logic       sda_in;
  } txn_t;

  typedef struct {
    logic [15:0] ticks;
    phase_t      ph;
    int unsigned dly;
    logic [3:0]  nbit;
    logic [7:0]  shreg;
    logic [7:0]  left;
    logic [6:0]  dev;
    logic        rd;
    logic        scl_lo;
    logic        sda_lo;
    logic        nak_seen;
  } bus_model_t;

  typedef struct {
    logic       scl_lo;
    logic       sda_lo;
    logic       need;
    logic       rvalid;
    logic [7:0] rdata;
    logic       done;
    logic       ok;
    logic       busy;
  } line_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_TICK;
  logic        in_is_read = 1'b0;
  logic [6:0]  in_addr7 = '0;
  logic [7:0]  in_length = '0;
  logic [7:0]  in_data_byte = '0;
  logic        in_scl_in = 1'b1;
  logic        in_sda_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_scl_pull_low;
  logic        out_sda_pull_low;
  logic        out_need_byte;
  logic        out_read_valid;
  logic [7:0]  out_read_data;
  logic        out_done_res;
  logic        out_success;
  logic        out_busy_res;

  // gen_m runs ahead with the stimulus, chk_m follows accepted transactions
  bus_model_t   gen_m;
  bus_model_t   chk_m;
  txn_t         tx_pending[$];
  line_result_t line_expect[$];
  txn_t         cur;
  line_result_t want;
  int           queued = 0;
  int           checked = 0;
  int           errors = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_run = 0;
  int           stall_mode = 0;
  longint unsigned cycles = 0;

  i2c_master_transaction_engine_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_is_read       (in_is_read),
    .in_addr7         (in_addr7),
    .in_length        (in_length),
    .in_data_byte     (in_data_byte),
    .in_scl_in        (in_scl_in),
    .in_sda_in        (in_sda_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scl_pull_low (out_scl_pull_low),
    .out_sda_pull_low (out_sda_pull_low),
    .out_need_byte    (out_need_byte),
    .out_read_valid   (out_read_valid),
    .out_read_data    (out_read_data),
    .out_done_res     (out_done_res),
    .out_success      (out_success),
    .out_busy_res     (out_busy_res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void model_clear(output bus_model_t m);
    m.ticks    = RESET_TICKS;
    m.ph       = PH_IDLE;
    m.dly      = 0;
    m.nbit     = '0;
    m.shreg    = '0;
    m.left     = '0;
    m.dev      = '0;
    m.rd       = 1'b0;
    m.scl_lo   = 1'b0;
    m.sda_lo   = 1'b0;
    m.nak_seen = 1'b0;
  endfunction

  function automatic void enter(inout bus_model_t m, input phase_t p);
    m.ph  = p;
    m.dly = 0;
  endfunction

  // a zero setting behaves as one tick
  function automatic bit delay_over(inout bus_model_t m);
    m.dly++;
    return m.dly >= ((m.ticks == 0) ? 1 : m.ticks);
  endfunction

  function automatic void drive_bit(inout bus_model_t m);
    m.sda_lo = !m.shreg[3'd7 - m.nbit[2:0]];
    enter(m, PH_TX_D1);
  endfunction

  function automatic void begin_stop(inout bus_model_t m);
    m.sda_lo = 1'b1;
    enter(m, PH_SP_D1);
  endfunction

  function automatic void begin_rx(inout bus_model_t m);
    m.sda_lo = 1'b0;
    m.nbit   = '0;
    m.shreg  = '0;
    enter(m, PH_RX_D1);
  endfunction

  function automatic line_result_t bus_step(inout bus_model_t m, input txn_t t);
    line_result_t r;
    bit got_byte;
    bit stopped;
    got_byte = 1'b0;
    stopped  = 1'b0;
    case (t.cmd)
      CMD_TICK: begin
        case (m.ph)
          // SCL released by the master: wait for the pin, then the next phase in order
          PH_ST_WAIT, PH_TX_WAIT, PH_ACK_WAIT, PH_RX_WAIT, PH_MA_WAIT, PH_SP_WAIT:
            if (t.scl_in) enter(m, phase_t'(m.ph + 5'd1));
          PH_TX_D1, PH_ACK_D1, PH_RX_D1, PH_MA_D1, PH_SP_D1:
            if (delay_over(m)) begin
              m.scl_lo = 1'b0;
              enter(m, phase_t'(m.ph + 5'd1));
            end
          PH_ST_D1:
            if (delay_over(m)) begin
              m.sda_lo = 1'b1;
              enter(m, PH_ST_D2);
            end
          PH_ST_D2:
            if (delay_over(m)) begin
              m.scl_lo = 1'b1;
              m.shreg  = {m.dev, m.rd};
              m.nbit   = '0;
              drive_bit(m);
            end
          PH_TX_D2:
            if (delay_over(m)) begin
              m.scl_lo = 1'b1;
              m.nbit++;
              if (m.nbit < 8) begin
                drive_bit(m);
              end else begin
                m.sda_lo = 1'b0;
                enter(m, PH_ACK_D1);
              end
            end
          PH_ACK_D2:
            if (delay_over(m)) begin
              m.scl_lo = 1'b1;
              if (t.sda_in) begin
                m.nak_seen = 1'b1;
                begin_stop(m);
              end else if (m.left == 0) begin
                begin_stop(m);
              end else if (m.rd) begin
                begin_rx(m);
              end else begin
                enter(m, PH_NEED);
              end
            end
          PH_RX_D2:
            if (delay_over(m)) begin
              m.shreg  = {m.shreg[6:0], t.sda_in};
              m.scl_lo = 1'b1;
              m.nbit++;
              if (m.nbit < 8) begin
                enter(m, PH_RX_D1);
              end else begin
                // byte reported now, before the master ACK/NAK is clocked
                m.left--;
                got_byte = 1'b1;
                m.sda_lo = (m.left != 0);
                enter(m, PH_MA_D1);
              end
            end
          PH_MA_D2:
            if (delay_over(m)) begin
              m.scl_lo = 1'b1;
              if (m.left == 0) begin_stop(m);
              else begin_rx(m);
            end
          PH_SP_D2:
            if (delay_over(m)) begin
              m.sda_lo = 1'b0;
              enter(m, PH_SP_D3);
            end
          PH_SP_D3:
            if (delay_over(m)) begin
              stopped = 1'b1;
              enter(m, PH_IDLE);
            end
          default: ;
        endcase
      end
      CMD_BEGIN: begin
        if (m.ph == PH_IDLE) begin
          m.rd       = t.is_read;
          m.dev      = t.addr7;
          m.left     = t.nbytes;
          m.nak_seen = 1'b0;
          m.scl_lo   = 1'b0;
          m.sda_lo   = 1'b0;
          m.nbit     = '0;
          m.shreg    = '0;
          enter(m, PH_ST_WAIT);
        end
      end
      CMD_SUPPLY: begin
        if (m.ph == PH_NEED) begin
          m.shreg = t.data_byte;
          m.left--;
          m.nbit  = '0;
          drive_bit(m);
        end
      end
      default: ;
    endcase
    r.scl_lo = m.scl_lo;
    r.sda_lo = m.sda_lo;
    r.need   = (m.ph == PH_NEED);
    r.rvalid = got_byte;
    r.rdata  = got_byte ? m.shreg : 8'd0;
    r.done   = stopped;
    r.ok     = stopped && !m.nak_seen;
    r.busy   = (m.ph != PH_IDLE);
    return r;
  endfunction

  function automatic txn_t random_txn();
    txn_t s;
    s.cmd       = 2'($urandom_range(0, 3));
    s.is_read   = 1'($urandom_range(0, 1));
    s.addr7     = 7'($urandom_range(0, 127));
    s.nbytes    = 8'($urandom_range(0, 255));
    s.data_byte = 8'($urandom_range(0, 255));
    s.scl_in    = 1'($urandom_range(0, 1));
    s.sda_in    = 1'($urandom_range(0, 1));
    return s;
  endfunction

  task automatic queue_item(input txn_t s);
    tx_pending.push_back(s);
    void'(bus_step(gen_m, s));
    queued++;
  endtask

  // only called while the engine is idle, so nothing here starts a transfer
  task automatic idle_noise(input int n);
    txn_t s;
    repeat (n) begin
      s = random_txn();
      case ($urandom_range(0, 2))
        0:       s.cmd = CMD_TICK;
        1:       s.cmd = CMD_SUPPLY;
        default: s.cmd = CMD_UNUSED;
      endcase
      queue_item(s);
    end
  endtask

  // One full bus transfer. nak_at: index of the acknowledge to refuse (0 is the
  // address), -1 for none. fill: fixed write data, -1 for random.
  task automatic drive_transfer(input bit rd, input logic [6:0] dev, input logic [7:0] len,
                                input int nak_at, input int fill);
    txn_t   s;
    int     acks;
    phase_t was;
    s         = random_txn();
    s.cmd     = CMD_BEGIN;
    s.is_read = rd;
    s.addr7   = dev;
    s.nbytes  = len;
    queue_item(s);
    // a second begin while busy has to be ignored
    s     = random_txn();
    s.cmd = CMD_BEGIN;
    queue_item(s);
    acks = 0;
    while (gen_m.ph != PH_IDLE) begin
      s     = random_txn();
      s.cmd = CMD_TICK;
      if (gen_m.ph == PH_NEED) begin
        if ($urandom_range(0, 3) != 0) begin
          s.cmd = CMD_SUPPLY;
          if (fill >= 0) s.data_byte = fill[7:0];
        end
      end else if ($urandom_range(0, 15) == 0) begin
        s.cmd = ($urandom_range(0, 1) != 0) ? CMD_BEGIN : CMD_UNUSED;
      end
      if (s.cmd == CMD_TICK) begin
        // mostly released SCL reads high; the rest models clock stretching
        s.scl_in = ($urandom_range(0, 3) != 0);
        if (gen_m.ph inside {PH_ACK_D1, PH_ACK_WAIT, PH_ACK_D2}) s.sda_in = (acks == nak_at);
      end
      was = gen_m.ph;
      queue_item(s);
      if (was == PH_ACK_D2 && gen_m.ph != PH_ACK_D2) acks++;
    end
  endtask

  task automatic random_transfers(input int budget);
    int start;
    int r;
    bit rd;
    int len;
    int nak;
    start = queued;
    while (queued - start < budget) begin
      rd = 1'($urandom_range(0, 1));
      r  = $urandom_range(0, 9);
      if (rd) begin
        len = $urandom_range(0, 3);
        nak = (r == 0) ? 0 : -1;
      end else if (r < 2) begin
        // writes of up to 255 bytes, cut short by a NAK on the address or on the first data byte, if any
        len = $urandom_range(0, 255);
        nak = $urandom_range(0, 1);
      end else begin
        len = $urandom_range(0, 3);
        nak = (r == 2) ? $urandom_range(0, len) : -1;
      end
      drive_transfer(rd, 7'($urandom_range(0, 127)), 8'(len), nak, -1);
      idle_noise($urandom_range(0, 3));
    end
  endtask

  // every queued transaction has had its result checked
  task automatic wait_drain();
    while (checked != queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_phase_ticks(input logic [15:0] v);
    wait_drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gen_m.ticks = v;
    chk_m.ticks = v;
  endtask

  task automatic cmp_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  // driver: bursts of transactions with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) line_expect.push_back(bus_step(chk_m, cur));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tx_pending.size() != 0) begin
          cur = tx_pending.pop_front();
          in_valid     <= 1'b1;
          in_cmd       <= cur.cmd;
          in_is_read   <= cur.is_read;
          in_addr7     <= cur.addr7;
          in_length    <= cur.nbytes;
          in_data_byte <= cur.data_byte;
          in_scl_in    <= cur.scl_in;
          in_sda_in    <= cur.sda_in;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares results and stalls in windows of its own
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (line_expect.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = line_expect.pop_front();
          checked++;
          cmp_field("scl_pull_low", 8'(want.scl_lo), 8'(out_scl_pull_low));
          cmp_field("sda_pull_low", 8'(want.sda_lo), 8'(out_sda_pull_low));
          cmp_field("need_byte", 8'(want.need), 8'(out_need_byte));
          cmp_field("read_valid", 8'(want.rvalid), 8'(out_read_valid));
          cmp_field("read_data", want.rdata, out_read_data);
          cmp_field("done_res", 8'(want.done), 8'(out_done_res));
          cmp_field("success", 8'(want.ok), 8'(out_success));
          cmp_field("busy_res", 8'(want.busy), 8'(out_busy_res));
        end
      end
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_run  = $urandom_range(4, 60);
      end else begin
        stall_run--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= (stall_run % 4 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    txn_t s;
    model_clear(gen_m);
    model_clear(chk_m);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // idle at the reset setting: unused command, stray supply, ticks on both pin levels
    s = '{CMD_UNUSED, 1'b1, 7'h7f, 8'hff, 8'hff, 1'b1, 1'b1};
    queue_item(s);
    s = '{CMD_SUPPLY, 1'b0, 7'h00, 8'h00, 8'hff, 1'b0, 1'b0};
    queue_item(s);
    s = '{CMD_TICK, 1'b0, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0};
    queue_item(s);
    s = '{CMD_TICK, 1'b1, 7'h7f, 8'hff, 8'hff, 1'b1, 1'b1};
    queue_item(s);

    // zero setting, one tick per phase
    set_phase_ticks(16'd0);
    drive_transfer(1'b0, 7'h7f, 8'd0, -1, -1);     // address only
    drive_transfer(1'b0, 7'h00, 8'd1, -1, 8'h00);
    drive_transfer(1'b0, 7'h2a, 8'd2, 1, 8'hff);   // data byte refused
    drive_transfer(1'b1, 7'h55, 8'd2, -1, -1);
    drive_transfer(1'b1, 7'h7f, 8'd1, 0, -1);      // address refused on a read
    drive_transfer(1'b0, 7'h33, 8'd255, 0, -1);

    set_phase_ticks(16'd2);
    random_transfers(30);

    // widest setting: idle traffic only, a transfer would take far too long
    set_phase_ticks(16'hffff);
    idle_noise(12);

    wait_drain();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/i2cm_pkg.sv
design/i2cm_front.sv
design/i2cm_engine.sv
design/i2c_master_transaction_engine_top.sv
test/tb.sv
